FILE: sv/fisher_exact_test_2x2_core_macros.svh
// assertion macros shared by the fisher exact test core
// depends on nothing; the using module supplies clk and rst
`ifndef FISHER_EXACT_TEST_2X2_CORE_MACROS_SVH
`define FISHER_EXACT_TEST_2X2_CORE_MACROS_SVH

// condition holds at every clock edge out of reset
`define FET_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define FET_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/fet_pkg.sv
// types, constants and elaboration-time table builders for the fisher exact test core
// used by every module of the core
package fet_pkg;

  localparam int CNT_W         = 10;
  localparam int SUM_W         = CNT_W + 2;
  localparam int MARG_W        = CNT_W + 1;
  localparam int P_W           = 33;
  localparam int Q_FRAC        = 20;
  localparam int EXP_SPAN      = 23;
  localparam int EXP_K_W       = $clog2(EXP_SPAN);
  localparam int MAX_TOTAL_DEF = 1023;

  localparam logic [63:0] ONE62   = 64'd1 << 62;
  localparam logic [63:0] LN2_Q62 = 64'h2C5C85FDF473DE6B;
  localparam logic [P_W-1:0] ONE32 = P_W'(64'd1 << 32);

  typedef struct packed {
    logic [CNT_W-1:0] count_a;
    logic [CNT_W-1:0] count_b;
    logic [CNT_W-1:0] count_c;
    logic [CNT_W-1:0] count_d;
  } fet_in_t;

  typedef struct packed {
    logic [P_W-1:0] p_value;
    logic           range_error;
  } fet_out_t;

  typedef struct packed {
    logic              err;
    logic [CNT_W-1:0]  a;
    logic [CNT_W-1:0]  b;
    logic [CNT_W-1:0]  c;
    logic [CNT_W-1:0]  d;
    logic [MARG_W-1:0] lo;
    logic [MARG_W-1:0] hi;
  } fet_job_t;

  typedef struct packed {
    logic               start;
    logic [EXP_K_W-1:0] k;
    logic [Q_FRAC-1:0]  f;
  } fet_exp_req_t;

  typedef struct packed {
    logic           done;
    logic [P_W-1:0] value;
  } fet_exp_rsp_t;

  typedef logic [63:0] fet_expint_t [0:EXP_SPAN-1];

  function automatic int lf_width(int m);
    return $clog2(m * $clog2(m + 1) + 2) + Q_FRAC;
  endfunction

  function automatic logic [63:0] mul62_f(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] exp_neg_q62_f(logic [63:0] x);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    logic        run;
    pos  = ONE62;
    neg  = '0;
    term = ONE62;
    run  = 1'b1;
    for (int j = 1; j <= 40; j++) begin
      if (run) begin
        term = mul62_f(term, x) / 64'(j);
        if (term == 64'd0) begin
          run = 1'b0;
        end else if ((j % 2) == 1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
    end
    return pos - neg;
  endfunction

  function automatic logic [63:0] ln_q58_f(logic [63:0] i);
    logic [63:0] p;
    logic [63:0] k;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] sum;
    logic        run;
    p = 64'd1;
    k = '0;
    for (int s = 0; s < 64; s++) begin
      if ((p << 1) <= i && (p << 1) != 64'd0) begin
        p = p << 1;
        k = k + 64'd1;
      end
    end
    num = i - p;
    den = i + p;
    sum = '0;
    if (num != 64'd0) begin
      rem = num;
      t   = '0;
      for (int n = 0; n < 62; n++) begin
        rem = rem << 1;
        t   = t << 1;
        if (rem >= den) begin
          rem = rem - den;
          t   = t | 64'd1;
        end
      end
      t2   = mul62_f(t, t);
      sum  = t;
      term = t;
      run  = 1'b1;
      for (int j = 3; j < 200; j += 2) begin
        if (run) begin
          term = mul62_f(term, t2);
          if (term == 64'd0) begin
            run = 1'b0;
          end else begin
            sum = sum + term / 64'(j);
          end
        end
      end
      sum = sum << 1;
    end
    return k * ((LN2_Q62 + 64'd8) >> 4) + ((sum + 64'd8) >> 4);
  endfunction

  function automatic fet_expint_t expint_build();
    fet_expint_t r;
    logic [63:0] e1;
    e1   = exp_neg_q62_f(ONE62);
    r[0] = ONE62;
    for (int i = 1; i < EXP_SPAN; i++) begin
      r[i] = mul62_f(r[i-1], e1);
    end
    return r;
  endfunction

endpackage

FILE: sv/fet_front.sv
// front part: takes requests, checks the total, finds the margin range and queues jobs
// depends on fet_pkg
module fet_front import fet_pkg::*; #(
  parameter int MAX_TOTAL = MAX_TOTAL_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  fet_in_t  request,
  output logic     busy,
  output fet_job_t job,
  output logic     job_valid,
  input  logic     pop
);

  localparam int QD = 2;

  fet_job_t         q [0:QD-1];
  logic [1:0]       count;
  logic             wr_ptr;
  logic             rd_ptr;
  logic             push;
  fet_job_t         job_in;
  logic [SUM_W-1:0] n;

  always_comb begin
    n = SUM_W'(request.count_a) + SUM_W'(request.count_b)
      + SUM_W'(request.count_c) + SUM_W'(request.count_d);
    job_in.err = 17'(n) > 17'(MAX_TOTAL);
    job_in.a   = request.count_a;
    job_in.b   = request.count_b;
    job_in.c   = request.count_c;
    job_in.d   = request.count_d;
    job_in.lo  = (request.count_a > request.count_d)
               ? MARG_W'(request.count_a) - MARG_W'(request.count_d) : '0;
    job_in.hi  = (request.count_b < request.count_c)
               ? MARG_W'(request.count_a) + MARG_W'(request.count_b)
               : MARG_W'(request.count_a) + MARG_W'(request.count_c);
  end

  assign busy      = (count == 2'(QD));
  assign push      = start && !busy;
  assign job_valid = (count != 2'd0);
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && job_valid) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop && job_valid);
    end
  end

endmodule

FILE: sv/fet_exp.sv
// exp unit: exp(-k-f) rounded to 32 fraction bits by series, one 32x32 multiplier
// and an 8 bit per cycle divider; depends on fet_pkg
module fet_exp import fet_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  fet_exp_req_t req,
  output fet_exp_rsp_t rsp
);

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_MUL  = 3'd1;
  localparam logic [2:0] E_LD   = 3'd2;
  localparam logic [2:0] E_DIV  = 3'd3;
  localparam logic [2:0] E_ACC  = 3'd4;
  localparam logic [2:0] E_FIN  = 3'd5;
  localparam logic [2:0] E_RND  = 3'd6;

  localparam fet_expint_t EXPINT = expint_build();
  localparam logic [5:0]  J_LAST = 6'd40;

  logic [2:0]         state;
  logic [EXP_K_W-1:0] k;
  logic [63:0]        x;
  logic [63:0]        pos;
  logic [63:0]        neg;
  logic [63:0]        ma;
  logic [63:0]        mb;
  logic [63:0]        pp;
  logic [1:0]         pidx;
  logic [127:0]       acc;
  logic [127:0]       pp_sh;
  logic [2:0]         mcnt;
  logic               fin;
  logic [5:0]         j;
  logic [63:0]        dvd;
  logic [5:0]         rem;
  logic [2:0]         dcnt;
  logic [63:0]        dvd_next;
  logic [5:0]         rem_next;
  logic [31:0]        opa;
  logic [31:0]        opb;
  logic [6:0]         r2;
  logic [63:0]        rnd;

  always_comb begin
    unique case (mcnt[1:0])
      2'd0: begin opa = ma[31:0];  opb = mb[31:0];  end
      2'd1: begin opa = ma[31:0];  opb = mb[63:32]; end
      2'd2: begin opa = ma[63:32]; opb = mb[31:0];  end
      default: begin opa = ma[63:32]; opb = mb[63:32]; end
    endcase
    unique case (pidx)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_comb begin
    dvd_next = dvd;
    rem_next = rem;
    for (int s = 0; s < 8; s++) begin
      r2 = {rem_next, dvd_next[63]};
      if (r2 >= 7'(j)) begin
        dvd_next = {dvd_next[62:0], 1'b1};
        rem_next = 6'(r2 - 7'(j));
      end else begin
        dvd_next = {dvd_next[62:0], 1'b0};
        rem_next = r2[5:0];
      end
    end
  end

  assign rnd = acc[125:62] + (64'd1 << 29);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= E_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        E_IDLE: begin
          if (req.start) begin
            k     <= req.k;
            x     <= {req.f, 44'd0} >> 2;
            ma    <= ONE62;
            mb    <= {req.f, 44'd0} >> 2;
            pos   <= ONE62;
            neg   <= '0;
            j     <= 6'd1;
            fin   <= 1'b0;
            acc   <= '0;
            mcnt  <= '0;
            state <= E_MUL;
          end
        end
        E_MUL: begin
          if (mcnt != 3'd4) begin
            pp   <= opa * opb;
            pidx <= mcnt[1:0];
          end
          if (mcnt != 3'd0) begin
            acc <= acc + pp_sh;
          end
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd4) begin
            state <= fin ? E_RND : E_LD;
          end
        end
        E_LD: begin
          dvd   <= acc[125:62];
          rem   <= '0;
          dcnt  <= '0;
          state <= E_DIV;
        end
        E_DIV: begin
          dvd  <= dvd_next;
          rem  <= rem_next;
          dcnt <= dcnt + 3'd1;
          if (dcnt == 3'd7) begin
            state <= E_ACC;
          end
        end
        E_ACC: begin
          if (dvd == 64'd0) begin
            state <= E_FIN;
          end else begin
            if (j[0]) begin
              neg <= neg + dvd;
            end else begin
              pos <= pos + dvd;
            end
            if (j == J_LAST) begin
              state <= E_FIN;
            end else begin
              j     <= j + 6'd1;
              ma    <= dvd;
              mb    <= x;
              acc   <= '0;
              mcnt  <= '0;
              state <= E_MUL;
            end
          end
        end
        E_FIN: begin
          ma    <= EXPINT[k];
          mb    <= pos - neg;
          fin   <= 1'b1;
          acc   <= '0;
          mcnt  <= '0;
          state <= E_MUL;
        end
        E_RND: begin
          rsp.done  <= 1'b1;
          rsp.value <= P_W'(rnd >> 30);
          state     <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/fet_back.sv
// back part: walks the tables with the same margins, reads the ln(k!) rom and sums exp terms
// depends on fet_pkg, fet_exp (driven from outside) and the assertion macros
`include "fisher_exact_test_2x2_core_macros.svh"
module fet_back import fet_pkg::*; #(
  parameter int MAX_TOTAL = MAX_TOTAL_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  fet_job_t     job,
  input  logic         job_valid,
  output logic         pop,
  output fet_exp_req_t exp_req,
  input  fet_exp_rsp_t exp_rsp,
  output logic         done,
  output fet_out_t     result
);

  localparam int LW    = lf_width(MAX_TOTAL);
  localparam int SW    = LW + 4;
  localparam int AW    = $clog2(MAX_TOTAL + 1);
  localparam int ACC_W = P_W + MARG_W + 1;

  typedef logic [LW-1:0] lf_rom_t [0:MAX_TOTAL];

  function automatic lf_rom_t lf_build();
    lf_rom_t     r;
    logic [63:0] acc;
    acc  = '0;
    r[0] = '0;
    for (int i = 1; i <= MAX_TOTAL; i++) begin
      acc  = acc + ((ln_q58_f(64'(i)) + (64'd1 << 17)) >> 18);
      r[i] = LW'((acc + (64'd1 << 19)) >> 20);
    end
    return r;
  endfunction

  localparam lf_rom_t        LF      = lf_build();
  localparam logic [SW-1:0]  EXP_LIM = SW'(EXP_SPAN) << Q_FRAC;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RD   = 2'd1;
  localparam logic [1:0] B_CMP  = 2'd2;
  localparam logic [1:0] B_EXP  = 2'd3;

  localparam logic [1:0] PH_K   = 2'd0;
  localparam logic [1:0] PH_OBS = 2'd1;
  localparam logic [1:0] PH_TBL = 2'd2;

  logic [1:0]         state;
  logic [1:0]         phase;
  fet_job_t           cur;
  logic [2:0]         rcnt;
  logic [2:0]         nreads;
  logic [MARG_W-1:0]  x;
  logic [LW-1:0]      rom_q;
  logic [AW-1:0]      rd_addr;
  logic [SUM_W-1:0]   sel;
  logic signed [SW-1:0] acc;
  logic signed [SW-1:0] acc_next;
  logic signed [SW-1:0] rom_ext;
  logic signed [SW-1:0] kreg;
  logic signed [SW-1:0] cutoff;
  logic signed [SW-1:0] lx;
  logic [SW-1:0]      u;
  logic               take;
  logic               need_exp;
  logic               step;
  logic [P_W-1:0]     add_val;
  logic [ACC_W-1:0]   sum;
  logic [ACC_W-1:0]   sum_next;
  logic [SUM_W-1:0]   ab;
  logic [SUM_W-1:0]   ac;
  logic [SUM_W-1:0]   cd;
  logic [SUM_W-1:0]   bd;
  logic [SUM_W-1:0]   nt;

  always_comb begin
    ab = SUM_W'(cur.a) + SUM_W'(cur.b);
    ac = SUM_W'(cur.a) + SUM_W'(cur.c);
    cd = SUM_W'(cur.c) + SUM_W'(cur.d);
    bd = SUM_W'(cur.b) + SUM_W'(cur.d);
    nt = ab + cd;
    nreads = (phase == PH_K) ? 3'd5 : 3'd4;
    sel = '0;
    unique case (phase)
      PH_K: begin
        case (rcnt)
          3'd0:    sel = ab;
          3'd1:    sel = cd;
          3'd2:    sel = ac;
          3'd3:    sel = bd;
          default: sel = nt;
        endcase
      end
      PH_OBS: begin
        case (rcnt)
          3'd0:    sel = SUM_W'(cur.a);
          3'd1:    sel = SUM_W'(cur.b);
          3'd2:    sel = SUM_W'(cur.c);
          default: sel = SUM_W'(cur.d);
        endcase
      end
      default: begin
        case (rcnt)
          3'd0:    sel = SUM_W'(x);
          3'd1:    sel = ab - SUM_W'(x);
          3'd2:    sel = ac - SUM_W'(x);
          default: sel = SUM_W'(cur.d) + SUM_W'(x) - SUM_W'(cur.a);
        endcase
      end
    endcase
    rd_addr = AW'(sel);
  end

  always_ff @(posedge clk) begin
    rom_q <= LF[rd_addr];
  end

  always_comb begin
    rom_ext  = $signed({{(SW-LW){1'b0}}, rom_q});
    acc_next = (phase == PH_K && rcnt <= 3'd4) ? acc + rom_ext : acc - rom_ext;
    u        = SW'(-lx);
    take     = (lx <= cutoff);
    need_exp = take && lx < 0 && u < EXP_LIM;
    add_val  = '0;
    step     = 1'b0;
    if (state == B_CMP && !need_exp) begin
      step    = 1'b1;
      add_val = (take && lx >= 0) ? ONE32 : '0;
    end else if (state == B_EXP && exp_rsp.done) begin
      step    = 1'b1;
      add_val = exp_rsp.value;
    end
    sum_next = sum + ACC_W'(add_val);
  end

  assign pop = (state == B_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      done          <= 1'b0;
      exp_req.start <= 1'b0;
    end else begin
      done          <= 1'b0;
      exp_req.start <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            cur <= job;
            if (job.err) begin
              done               <= 1'b1;
              result.p_value     <= '0;
              result.range_error <= 1'b1;
            end else begin
              phase <= PH_K;
              rcnt  <= '0;
              acc   <= '0;
              sum   <= '0;
              state <= B_RD;
            end
          end
        end
        B_RD: begin
          rcnt <= rcnt + 3'd1;
          if (rcnt != 3'd0) begin
            acc <= acc_next;
          end
          if (rcnt == nreads) begin
            rcnt <= '0;
            unique case (phase)
              PH_K: begin
                kreg  <= acc_next;
                phase <= PH_OBS;
              end
              PH_OBS: begin
                cutoff <= acc_next;
                acc    <= kreg;
                x      <= cur.lo;
                phase  <= PH_TBL;
              end
              default: begin
                lx    <= acc_next;
                state <= B_CMP;
              end
            endcase
          end
        end
        B_CMP: begin
          if (need_exp) begin
            exp_req.start <= 1'b1;
            exp_req.k     <= u[Q_FRAC +: EXP_K_W];
            exp_req.f     <= u[Q_FRAC-1:0];
            state         <= B_EXP;
          end
        end
        B_EXP: begin
        end
        default: state <= B_IDLE;
      endcase
      if (step) begin
        sum <= sum_next;
        if (x == cur.hi) begin
          done               <= 1'b1;
          result.p_value     <= (sum_next > ACC_W'(ONE32)) ? ONE32 : P_W'(sum_next);
          result.range_error <= 1'b0;
          state              <= B_IDLE;
        end else begin
          x     <= x + MARG_W'(1);
          acc   <= kreg;
          rcnt  <= '0;
          state <= B_RD;
        end
      end
    end
  end

  `FET_ASSERT_IMP(a_err_zero, done && result.range_error, result.p_value == '0, "error result with nonzero p")
  `FET_ASSERT_IMP(a_p_sat, done, result.p_value <= ONE32, "p value above one")
  `FET_ASSERT_IMP(a_x_range, state == B_RD && phase == PH_TBL, x >= cur.lo && x <= cur.hi, "walk left margin range")
  `FET_ASSERT_IMP(a_exp_idle, exp_req.start, state == B_EXP, "exp request outside wait state")

endmodule

FILE: sv/fisher_exact_test_2x2_core.sv
// top level of the two-sided fisher exact test core for 2x2 count tables
// depends on fet_pkg, fet_front, fet_back and fet_exp
//
// A request is taken when start is high and busy is low; up to two requests queue
// ahead of the worker. Each request gives exactly one result on result, marked by a
// one-cycle done pulse, in request order; the receiver cannot stall it, so sample it
// when done is high. A total above MAX_TOTAL gives range_error with p_value zero
// in the cycle after it reaches the worker. Otherwise the worker first works on the
// observed table, then on each of the T tables in the margin range (T = hi - lo + 1,
// at most MAX_TOTAL + 1); every table whose term is counted and needs an
// exponential waits on the single exp unit, which sums up to 40 series terms
// with one 32x32 multiplier and an 8 bit per cycle divider. The ln(k!) rom is
// a constant table read once per cycle.
module fisher_exact_test_2x2_core import fet_pkg::*; #(
  parameter int MAX_TOTAL = MAX_TOTAL_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  fet_in_t  request,
  output logic     busy,
  output logic     done,
  output fet_out_t result
);

  fet_job_t     job;
  logic         job_valid;
  logic         pop;
  fet_exp_req_t exp_req;
  fet_exp_rsp_t exp_rsp;

  fet_front #(.MAX_TOTAL(MAX_TOTAL)) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .job       (job),
    .job_valid (job_valid),
    .pop       (pop)
  );

  fet_exp u_exp (
    .clk (clk),
    .rst (rst),
    .req (exp_req),
    .rsp (exp_rsp)
  );

  fet_back #(.MAX_TOTAL(MAX_TOTAL)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .pop       (pop),
    .exp_req   (exp_req),
    .exp_rsp   (exp_rsp),
    .done      (done),
    .result    (result)
  );

endmodule
